// File: hdl/pidsd_pkg.sv
// Shared constants, register index codes and helper functions for the
// PID step with settle detection. No dependencies.
package pidsd_pkg;

  // Payload and state widths
  localparam int unsigned ERR_W     = 32;
  localparam int unsigned INT_W     = 48;
  localparam int unsigned CNT_W     = 21;
  localparam int unsigned GAIN_W    = 24;
  localparam int unsigned ZONE_W    = 31;
  localparam int unsigned MS_W      = 20;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 3;

  // Arithmetic widths
  localparam int unsigned MAG_W   = INT_W;          // widest operand magnitude
  localparam int unsigned SPLIT_W = 24;             // low slice of a magnitude
  localparam int unsigned FRAC_W  = 16;             // gain fraction bits
  localparam int unsigned PROD_W  = 2 * SPLIT_W;    // one partial product
  localparam int unsigned RAW_W   = PROD_W + SPLIT_W - FRAC_W + 1;
  localparam int unsigned TERM_W  = RAW_W + 1;      // signed term
  localparam int unsigned SUM_W   = TERM_W + 2;     // sum of three terms

  // Lanes of the three PID terms
  localparam int unsigned LANE_N = 3;
  localparam int unsigned LANE_P = 0;
  localparam int unsigned LANE_I = 1;
  localparam int unsigned LANE_D = 2;

  // Pipeline depth: input, state, magnitude, product, term, output
  localparam int unsigned PIPE_N = 6;

  // Counter step per control tick, in ms
  localparam int unsigned TICK_MS = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
  localparam logic [ERR_W-1:0] OUT_MAX = {1'b0, {(ERR_W-1){1'b1}}};
  localparam logic [ERR_W-1:0] OUT_MIN = {1'b1, {(ERR_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_ZONE  = 3'd3,
    REG_SETTLE_BAND = 3'd4,
    REG_SETTLE_MS   = 3'd5,
    REG_TIMEOUT_MS  = 3'd6
  } cfg_idx_e;

  // Add one tick to a ms counter, saturating at all ones
  function automatic logic [CNT_W-1:0] cnt_tick(input logic [CNT_W-1:0] c);
    logic [CNT_W:0] n;
    n = {1'b0, c} + (CNT_W+1)'(TICK_MS);
    cnt_tick = n[CNT_W] ? CNT_MAX : n[CNT_W-1:0];
  endfunction

  // Two's complement magnitude of a sign-extended value
  function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W:0] v);
    logic [MAG_W:0] n;
    n = ~v + 1'b1;
    mag_of = v[MAG_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

// File: hdl/pid_step_with_settle_detect.sv
// PID step with integral zone and settle detection, six-stage pipeline.
// Depends on pidsd_pkg.
//
// Usage:
//  - Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 prop
//    gain, 1 integral gain, 2 derivative gain, 3 integral zone, 4 settle
//    band, 5 settle ms, 6 timeout ms). Unknown indexes are ignored. Write
//    only while no beat is in flight.
//  - Input channel: one signed Q16.16 error beat per control tick, taken
//    when in_valid_i is high and in_stall_o is low.
//  - Output channel: drive_o (signed Q16.16, saturated) and settled_o,
//    offered on out_valid_o and held while out_stall_i is high.
//  - Throughput: one beat per cycle while the output is not stalled. The
//    integral, previous error and ms counters are updated in a single
//    stage, so a beat may follow in the next cycle; the 24x48 integral
//    product is split in two 24x24 multipliers.
//  - Stall: every stage holds a valid bit; empty stages keep filling while
//    the output is stalled, and in_stall_o rises only once the whole pipe
//    is full behind a stalled output.
//  - Reset: clears registers, integral, previous error, counters, valids.
module pid_step_with_settle_detect (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pidsd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pidsd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [pidsd_pkg::ERR_W-1:0] err_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [pidsd_pkg::ERR_W-1:0] drive_o,
  output logic                            settled_o
);
  import pidsd_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0] gain_q [LANE_N];
  logic [ZONE_W-1:0] integ_zone_q, settle_band_q;
  logic [MS_W-1:0]   settle_ms_q, timeout_ms_q;

  // Controller state
  logic [INT_W-1:0] integ_q, integ_d;
  logic [ERR_W-1:0] last_err_q;
  logic [CNT_W-1:0] settle_cnt_q, settle_cnt_d;
  logic [CNT_W-1:0] run_cnt_q, run_cnt_d;

  // Pipeline control
  logic [PIPE_N-1:0] vld_q, vld_d, ready;
  logic              s1_fire;

  // Pipeline payload
  logic [ERR_W-1:0]  s1_err_q;
  logic [ERR_W-1:0]  s2_err_q;
  logic [INT_W-1:0]  s2_int_q;
  logic [ERR_W:0]    s2_diff_q;
  logic              s2_flag_q;
  logic [MAG_W-1:0]  s3_mag_q [LANE_N];
  logic [MAG_W-1:0]  s3_mag_d [LANE_N];
  logic [LANE_N-1:0] s3_neg_q, s3_neg_d;
  logic              s3_flag_q;
  logic [PROD_W-1:0] s4_phi_q [LANE_N];
  logic [PROD_W-1:0] s4_plo_q [LANE_N];
  logic [PROD_W-1:0] s4_phi_d [LANE_N];
  logic [PROD_W-1:0] s4_plo_d [LANE_N];
  logic [LANE_N-1:0] s4_neg_q;
  logic              s4_flag_q;
  logic [TERM_W-1:0] s5_term_q [LANE_N];
  logic [TERM_W-1:0] s5_term_d [LANE_N];
  logic              s5_flag_q;
  logic [ERR_W-1:0]  drive_q, drive_d;
  logic              settled_q;

  // Stage 1 signals
  logic [ERR_W-1:0] s1_aerr;
  logic             s1_in_zone, s1_in_band, s1_clear, s1_flag;
  logic             s1_err_pos, s1_err_neg, s1_last_pos, s1_last_neg;
  logic [INT_W:0]   s1_int_sum;
  logic [INT_W-1:0] s1_int_add;
  logic [ERR_W:0]   s1_diff;

  // Output stage signals
  logic [SUM_W-1:0]     s5_sum;
  logic [SUM_W-ERR_W:0] s5_hi;

  // Handshake: a stage loads when it is empty or its successor moves on
  always_comb begin
    ready[PIPE_N-1] = !vld_q[PIPE_N-1] || !out_stall_i;
    for (int i = PIPE_N - 2; i >= 0; i--) begin
      ready[i] = !vld_q[i] || ready[i+1];
    end
    vld_d[0] = ready[0] ? in_valid_i : vld_q[0];
    for (int i = 1; i < PIPE_N; i++) begin
      vld_d[i] = ready[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  assign s1_fire    = vld_q[0] && ready[1];
  assign in_stall_o = !ready[0];

  // Stage 1: integral, previous error and counters
  always_comb begin
    s1_aerr    = ERR_W'(mag_of({{(MAG_W-ERR_W+1){s1_err_q[ERR_W-1]}}, s1_err_q}));
    s1_in_zone = s1_aerr < {1'b0, integ_zone_q};
    s1_in_band = s1_aerr < {1'b0, settle_band_q};

    s1_int_sum = {integ_q[INT_W-1], integ_q}
               + {{(INT_W-ERR_W+1){s1_err_q[ERR_W-1]}}, s1_err_q};
    if (s1_int_sum[INT_W] != s1_int_sum[INT_W-1]) begin
      s1_int_add = s1_int_sum[INT_W] ? INT_MIN : INT_MAX;
    end else begin
      s1_int_add = s1_int_sum[INT_W-1:0];
    end

    // sign change against the previous error clears the integral
    s1_err_neg  = s1_err_q[ERR_W-1];
    s1_err_pos  = !s1_err_q[ERR_W-1] && (s1_err_q != '0);
    s1_last_neg = last_err_q[ERR_W-1];
    s1_last_pos = !last_err_q[ERR_W-1] && (last_err_q != '0);
    s1_clear    = (s1_err_pos && s1_last_neg) || (s1_err_neg && s1_last_pos);

    if (s1_clear) begin
      integ_d = '0;
    end else if (s1_in_zone) begin
      integ_d = s1_int_add;
    end else begin
      integ_d = integ_q;
    end

    s1_diff = {s1_err_q[ERR_W-1], s1_err_q} - {last_err_q[ERR_W-1], last_err_q};

    settle_cnt_d = s1_in_band ? cnt_tick(settle_cnt_q) : '0;
    run_cnt_d    = cnt_tick(run_cnt_q);
    s1_flag      = ((run_cnt_d > {1'b0, timeout_ms_q}) && (timeout_ms_q != '0))
                || (settle_cnt_d > {1'b0, settle_ms_q});
  end

  // Stage 2: magnitudes and signs of the three operands
  always_comb begin
    s3_mag_d[LANE_P] = mag_of({{(MAG_W-ERR_W+1){s2_err_q[ERR_W-1]}}, s2_err_q});
    s3_mag_d[LANE_I] = mag_of({s2_int_q[INT_W-1], s2_int_q});
    s3_mag_d[LANE_D] = mag_of({{(MAG_W-ERR_W){s2_diff_q[ERR_W]}}, s2_diff_q});
    s3_neg_d[LANE_P] = s2_err_q[ERR_W-1];
    s3_neg_d[LANE_I] = s2_int_q[INT_W-1];
    s3_neg_d[LANE_D] = s2_diff_q[ERR_W];
  end

  // Stage 3: split products gain * high slice and gain * low slice
  // Stage 4: recombine, scale by 2^-16 and restore the sign
  for (genvar k = 0; k < LANE_N; k++) begin : g_lane
    logic [RAW_W-1:0]  raw;
    logic [TERM_W-1:0] mag_ext;

    assign s4_phi_d[k] = PROD_W'(gain_q[k]) * PROD_W'(s3_mag_q[k][MAG_W-1:SPLIT_W]);
    assign s4_plo_d[k] = PROD_W'(gain_q[k]) * PROD_W'(s3_mag_q[k][SPLIT_W-1:0]);

    assign raw = {1'b0, s4_phi_q[k], {(SPLIT_W-FRAC_W){1'b0}}}
               + RAW_W'(s4_plo_q[k][PROD_W-1:FRAC_W]);
    assign mag_ext      = {1'b0, raw};
    assign s5_term_d[k] = s4_neg_q[k] ? (~mag_ext + 1'b1) : mag_ext;
  end

  // Stage 5: sum the terms and saturate to 32 bits
  always_comb begin
    s5_sum = {{2{s5_term_q[LANE_P][TERM_W-1]}}, s5_term_q[LANE_P]}
           + {{2{s5_term_q[LANE_I][TERM_W-1]}}, s5_term_q[LANE_I]}
           + {{2{s5_term_q[LANE_D][TERM_W-1]}}, s5_term_q[LANE_D]};
    s5_hi  = s5_sum[SUM_W-1:ERR_W-1];
    if ((s5_hi == '0) || (s5_hi == '1)) begin
      drive_d = s5_sum[ERR_W-1:0];
    end else begin
      drive_d = s5_sum[SUM_W-1] ? OUT_MIN : OUT_MAX;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LANE_N; k++) begin
        gain_q[k] <= '0;
      end
      integ_zone_q  <= '0;
      settle_band_q <= '0;
      settle_ms_q   <= '0;
      timeout_ms_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_PROP_GAIN:   gain_q[LANE_P] <= cfg_wdata_i[GAIN_W-1:0];
        REG_INTEG_GAIN:  gain_q[LANE_I] <= cfg_wdata_i[GAIN_W-1:0];
        REG_DERIV_GAIN:  gain_q[LANE_D] <= cfg_wdata_i[GAIN_W-1:0];
        REG_INTEG_ZONE:  integ_zone_q   <= cfg_wdata_i[ZONE_W-1:0];
        REG_SETTLE_BAND: settle_band_q  <= cfg_wdata_i[ZONE_W-1:0];
        REG_SETTLE_MS:   settle_ms_q    <= cfg_wdata_i[MS_W-1:0];
        REG_TIMEOUT_MS:  timeout_ms_q   <= cfg_wdata_i[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      integ_q      <= '0;
      last_err_q   <= '0;
      settle_cnt_q <= '0;
      run_cnt_q    <= '0;
    end else begin
      vld_q <= vld_d;
      if (s1_fire) begin
        integ_q      <= integ_d;
        last_err_q   <= s1_err_q;
        settle_cnt_q <= settle_cnt_d;
        run_cnt_q    <= run_cnt_d;
      end
    end
  end

  // Pipeline payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      s1_err_q <= err_sample_i;
    end
    if (ready[1]) begin
      s2_err_q  <= s1_err_q;
      s2_int_q  <= integ_d;
      s2_diff_q <= s1_diff;
      s2_flag_q <= s1_flag;
    end
    if (ready[2]) begin
      s3_mag_q  <= s3_mag_d;
      s3_neg_q  <= s3_neg_d;
      s3_flag_q <= s2_flag_q;
    end
    if (ready[3]) begin
      s4_phi_q  <= s4_phi_d;
      s4_plo_q  <= s4_plo_d;
      s4_neg_q  <= s3_neg_q;
      s4_flag_q <= s3_flag_q;
    end
    if (ready[4]) begin
      s5_term_q <= s5_term_d;
      s5_flag_q <= s4_flag_q;
    end
    if (ready[5]) begin
      drive_q   <= drive_d;
      settled_q <= s5_flag_q;
    end
  end

  assign out_valid_o = vld_q[PIPE_N-1];
  assign drive_o     = drive_q;
  assign settled_o   = settled_q;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld_q == '1) && out_stall_i)
    else $error("input stalled while the pipeline has room");

  a_run_cnt_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> run_cnt_q != '0)
    else $error("run counter did not advance on a beat");

  a_settle_le_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    settle_cnt_q <= run_cnt_q)
    else $error("settled time exceeds run time");

  a_sign_change_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_clear |=> integ_q == '0)
    else $error("integral not cleared on error sign change");

endmodule

// File: sim/pid_step_with_settle_detect_tb.sv
// Self-checking testbench for pid_step_with_settle_detect: drives error beats,
// predicts drive and settled flag per beat and checks every output beat.
// Depends on pidsd_pkg and the pid_step_with_settle_detect RTL.
`timescale 1ns / 100ps

module pid_step_with_settle_detect_tb;
  import pidsd_pkg::*;

  localparam int ACC_W          = 80;      // wide enough for any gain * operand
  localparam int Q_FRAC         = 16;
  localparam int TICK_STEP_MS   = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 3'd7;

  localparam logic signed [INT_W+1:0] INTEG_TOP = {3'b000, {(INT_W-1){1'b1}}};
  localparam logic signed [INT_W+1:0] INTEG_BOT = {3'b111, {(INT_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] DRIVE_TOP = 80'sh7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] DRIVE_BOT = -80'sh8000_0000;
  localparam logic signed [ERR_W-1:0] NEAR_FULL = 32'sh7FFF_FFFE;

  typedef struct packed {
    logic signed [ERR_W-1:0] drive;
    logic                    settled;
  } pid_result_t;

  // DUT connections
  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx_i   = '0;
  logic [CFG_W-1:0]            cfg_wdata_i = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic signed [ERR_W-1:0]     err_sample_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [ERR_W-1:0]     drive_o;
  logic                        settled_o;

  // Predictor copy of the registers and controller state
  logic [GAIN_W-1:0]       gain_p = '0, gain_i = '0, gain_d = '0;
  logic [ZONE_W-1:0]       zone_lim = '0, band_lim = '0;
  logic [MS_W-1:0]         settle_lim = '0, timeout_lim = '0;
  logic signed [INT_W-1:0] integ_acc = '0;
  logic signed [ERR_W-1:0] prev_err = '0;
  logic [CNT_W-1:0]        band_ms = '0, run_ms = '0;

  pid_result_t pending_drive_q[$];
  int error_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  pid_step_with_settle_detect u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .err_sample_i(err_sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .settled_o   (settled_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  // Q8.16 gain times Q16.16 operand, magnitude truncated back to Q16.16
  function automatic logic signed [ACC_W-1:0] q16_term(input logic [GAIN_W-1:0] gain,
                                                       input logic signed [INT_W+1:0] v);
    logic [INT_W+1:0] mag;
    logic [ACC_W-1:0] prod;
    mag  = v[INT_W+1] ? -v : v;
    prod = ACC_W'(gain) * ACC_W'(mag);
    prod = prod >> Q_FRAC;
    return v[INT_W+1] ? -$signed(prod) : $signed(prod);
  endfunction

  // ms counter step, pinned at all ones
  function automatic logic [CNT_W-1:0] add_tick(input logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W+1)'(TICK_STEP_MS);
    return (s > {1'b0, {CNT_W{1'b1}}}) ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // One control tick: update integral, previous error and counters
  function automatic pid_result_t pid_predict(input logic signed [ERR_W-1:0] e);
    logic signed [INT_W+1:0] e_x, acc, diff;
    logic [ERR_W-1:0]        mag;
    logic signed [ACC_W-1:0] total;
    pid_result_t             r;
    e_x = e;
    mag = e[ERR_W-1] ? -e : e;
    // integral zone with clamp at the 48-bit limits
    if (mag < {1'b0, zone_lim}) begin
      acc = integ_acc + e_x;
      if (acc > INTEG_TOP) acc = INTEG_TOP;
      if (acc < INTEG_BOT) acc = INTEG_BOT;
      integ_acc = acc[INT_W-1:0];
    end
    // strict sign flip against the previous sample clears the integral
    if ((e > 0 && prev_err < 0) || (e < 0 && prev_err > 0)) integ_acc = '0;
    diff  = e_x - prev_err;
    total = q16_term(gain_p, e_x) + q16_term(gain_i, integ_acc) + q16_term(gain_d, diff);
    if (total > DRIVE_TOP) r.drive = 32'h7FFF_FFFF;
    else if (total < DRIVE_BOT) r.drive = 32'h8000_0000;
    else r.drive = total[ERR_W-1:0];
    prev_err = e;
    band_ms  = (mag < {1'b0, band_lim}) ? add_tick(band_ms) : '0;
    run_ms   = add_tick(run_ms);
    r.settled = ((run_ms > CNT_W'(timeout_lim)) && (timeout_lim != '0)) ||
                (band_ms > CNT_W'(settle_lim));
    return r;
  endfunction

  // ------------------------------------------------------------ bus processes

  // Input monitor: predict on every accepted beat
  always @(posedge clk_i) begin : input_monitor
    pid_result_t pred_r;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pred_r = pid_predict(err_sample_i);
      pending_drive_q.insert(pending_drive_q.size(), pred_r);
    end
  end

  // Output checker
  always @(posedge clk_i) begin : result_check
    pid_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_drive_q.size() == 0) begin
        $error("unexpected result beat: drive %0d settled %0b", drive_o, settled_o);
        error_count++;
      end else begin
        exp_r = pending_drive_q.pop_front();
        if (drive_o !== exp_r.drive) begin
          $error("drive: expected %0d, got %0d", exp_r.drive, drive_o);
          error_count++;
        end
        if (settled_o !== exp_r.settled) begin
          $error("settled: expected %0b, got %0b", exp_r.settled, settled_o);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: too long without a beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ------------------------------------------------------------ shared tasks

  // Offer one beat, with random idle cycles in front; returns at the accept edge
  task automatic send_beat(input logic signed [ERR_W-1:0] v);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    err_sample_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stop sending and wait until every expected result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_drive_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_PROP_GAIN:   gain_p      = data[GAIN_W-1:0];
      REG_INTEG_GAIN:  gain_i      = data[GAIN_W-1:0];
      REG_DERIV_GAIN:  gain_d      = data[GAIN_W-1:0];
      REG_INTEG_ZONE:  zone_lim    = data[ZONE_W-1:0];
      REG_SETTLE_BAND: band_lim    = data[ZONE_W-1:0];
      REG_SETTLE_MS:   settle_lim  = data[MS_W-1:0];
      REG_TIMEOUT_MS:  timeout_lim = data[MS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [ERR_W-1:0] extreme_err(input int k);
    case (k)
      0:       return 32'sh0000_0000;
      1:       return 32'sh0000_0001;
      2:       return -32'sh0000_0001;
      3:       return 32'sh7FFF_FFFF;
      4:       return 32'sh8000_0000;
      default: return NEAR_FULL;
    endcase
  endfunction

  function automatic logic signed [ERR_W-1:0] rand_err();
    logic signed [ERR_W-1:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = $urandom_range(0, 32'h0004_0000);
      3, 4:    v = $urandom_range(0, 32'h0100_0000);
      5:       v = extreme_err($urandom_range(0, 5));
      default: v = $urandom();
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Upper data bits beyond the register width are left random on purpose
  function automatic logic [CFG_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_W'(24'hFF_FFFF);
      2, 3:    return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2:       return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(0, 32'h0040_0000));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_ms();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_W'(20'hF_FFFF);
      2:       return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(0, 400));
    endcase
  endfunction

  task automatic randomize_config();
    logic [CFG_W-1:0] tmo;
    write_reg(REG_PROP_GAIN, pick_gain());
    write_reg(REG_INTEG_GAIN, pick_gain());
    write_reg(REG_DERIV_GAIN, pick_gain());
    write_reg(REG_INTEG_ZONE, pick_level());
    write_reg(REG_SETTLE_BAND, pick_level());
    write_reg(REG_SETTLE_MS, pick_ms());
    // timeout: off, extreme, or just ahead of the run time so it trips soon
    case ($urandom_range(0, 5))
      0, 1:    tmo = '0;
      2:       tmo = CFG_W'(20'hF_FFFF);
      3:       tmo = CFG_W'($urandom());
      default: tmo = CFG_W'(run_ms) + CFG_W'($urandom_range(10, 1500));
    endcase
    write_reg(REG_TIMEOUT_MS, tmo);
    if ($urandom_range(0, 3) == 0) write_reg(REG_OUT_OF_RANGE, CFG_W'($urandom()));
  endtask

  // Error trajectories: mostly decaying or ringing toward zero, some noise
  task automatic run_random(input int n);
    longint cur;
    int     kind, len, left, i;
    left = n;
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(4, 40);
      if (len > left) len = left;
      cur  = rand_err();
      for (i = 0; i < len; i++) begin
        case (kind)
          8: send_beat(rand_err());
          9: send_beat(extreme_err($urandom_range(0, 5)));
          default: send_beat(cur[ERR_W-1:0]);
        endcase
        if (kind < 5) begin
          cur = cur * longint'($urandom_range(4, 7)) / 8 +
                longint'($urandom_range(0, 4096)) - 2048;
        end else begin
          cur = -(cur * longint'($urandom_range(5, 7)) / 8);
        end
        if (cur > 64'sh7FFF_FFFF) cur = 64'sh7FFF_FFFF;
        if (cur < -64'sh8000_0000) cur = -64'sh8000_0000;
      end
      left -= len;
    end
  endtask

  // ------------------------------------------------------------ tests

  // Registers at reset are all zero: drive 0, flag low
  task automatic test_reset_defaults();
    send_beat(32'sh7FFF_FFFF);
    send_beat(32'sh8000_0000);
  endtask

  // Zone and band boundaries, sign flips, zero samples
  task automatic test_directed_math();
    drain_results();
    write_reg(REG_PROP_GAIN, 31'h1_0000);
    write_reg(REG_INTEG_GAIN, 31'h8000);
    write_reg(REG_DERIV_GAIN, 31'h4000);
    write_reg(REG_INTEG_ZONE, 31'hA_0000);
    write_reg(REG_SETTLE_BAND, 31'h1_0000);
    write_reg(REG_SETTLE_MS, 31'd20);
    write_reg(REG_TIMEOUT_MS, 31'd0);
    write_reg(REG_OUT_OF_RANGE, '1);
    send_beat(32'sh0);
    send_beat(32'sh1_0000);      // on the band edge: leaves the band
    send_beat(32'sh8000);
    send_beat(-32'sh8000);       // sign flip clears the integral
    send_beat(32'sh0);           // zero never clears
    send_beat(32'sh4000);        // previous zero never clears
    send_beat(32'shA_0000);      // on the zone edge: not integrated
    send_beat(32'sh9_FFFF);
    send_beat(32'sh1_0000);
    send_beat(32'shFFFF);
    send_beat(32'shFFFF);
    send_beat(32'shFFFF);        // band time now past settle time
    send_beat(-32'sh9_FFFF);
    // full-scale gains push drive into both rails
    drain_results();
    write_reg(REG_PROP_GAIN, 31'hFF_FFFF);
    write_reg(REG_INTEG_GAIN, 31'hFF_FFFF);
    write_reg(REG_DERIV_GAIN, 31'hFF_FFFF);
    write_reg(REG_INTEG_ZONE, 31'h7FFF_FFFF);
    write_reg(REG_SETTLE_BAND, 31'd0);
    send_beat(32'sh7FFF_FFFF);
    send_beat(32'sh8000_0000);
    send_beat(32'sh1);
    send_beat(-32'sh1);
    send_beat(32'sh0);
  endtask

  // Timeout on and off, run time already well past the limit
  task automatic test_timeout_flag();
    drain_results();
    write_reg(REG_TIMEOUT_MS, 31'd30);
    send_beat(32'sh2_0000);
    send_beat(-32'sh2_0000);
    drain_results();
    write_reg(REG_TIMEOUT_MS, 31'd0);
    send_beat(32'sh2_0000);
    send_beat(32'sh0);
  endtask

  // Long output hold-off fills the pipe; then a full pause and stalled traffic
  task automatic test_pressure();
    drain_results();
    randomize_config();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 60;
    repeat (40) send_beat(rand_err());
    drain_results();
    stall_pct = 58;
    repeat (12) send_beat(rand_err());
    drain_results();
    stall_pct = 0;
  endtask

  // Random traffic under each idling mix, fresh registers per chunk
  task automatic test_random_phases();
    int phase;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 58; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 32; stall_pct = 32; end
      endcase
      repeat (3) begin
        drain_results();
        randomize_config();
        run_random(100);
      end
    end
  endtask

  // Long one-sided runs at full rate with zone and band wide open
  task automatic test_long_saturation();
    drain_results();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_reg(REG_PROP_GAIN, '0);
    write_reg(REG_INTEG_GAIN, 31'd1);
    write_reg(REG_DERIV_GAIN, '0);
    write_reg(REG_INTEG_ZONE, 31'h7FFF_FFFF);
    write_reg(REG_SETTLE_BAND, 31'h7FFF_FFFF);
    write_reg(REG_SETTLE_MS, 31'hF_FFFF);
    write_reg(REG_TIMEOUT_MS, '0);
    repeat (30) send_beat(NEAR_FULL);
    // step down without a sign flip
    send_beat(32'sh0);
    send_beat(-32'sh2_0000);
    repeat (30) send_beat(-NEAR_FULL);
    send_beat(32'sh0);
    send_beat(32'sh2_0000);
    send_beat(32'sh8000_0000);   // out of the band: band time restarts
    send_beat(32'sh1);
  endtask

  // ------------------------------------------------------------ sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed_math();
    test_timeout_flag();
    test_pressure();
    test_random_phases();
    test_long_saturation();
    drain_results();
    repeat (4 * PIPE_N) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
